### hdl/sbt_pkg.sv
`timescale 1ns / 1ps
// Package for the slice boundary table: field widths, command and register codes,
// and the controller/datapath command and status structs. No dependencies.
package sbt_pkg;

  localparam int MAX_SLICES_DEF = 64;
  localparam int FRAME_BITS_DEF = 32;

  localparam int MODE_W   = 3;
  localparam int SLOT_W   = 6;
  localparam int IO_W     = 32;
  localparam int COUNT_W  = 7;
  localparam int MIN_BITS = 24;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  localparam logic [MIN_BITS-1:0] MIN_RESET = 24'd1;

  // register index (paddr[2])
  localparam logic REG_MIN_SLICE = 1'b0;

  localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_APPEND = 3'd1;
  localparam logic [MODE_W-1:0] MODE_MOVE   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_INSERT = 3'd3;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd4;
  localparam logic [MODE_W-1:0] MODE_READ   = 3'd5;

  typedef logic [4:0] op_t;

  localparam op_t OP_NONE      = 5'd0;
  localparam op_t OP_LATCH     = 5'd1;
  localparam op_t OP_CLEAR     = 5'd2;
  localparam op_t OP_APPEND    = 5'd3;
  localparam op_t OP_RD_ISSUE  = 5'd4;
  localparam op_t OP_RD_LOAD   = 5'd5;
  localparam op_t OP_MV_ISSUE  = 5'd6;
  localparam op_t OP_MV_CALC   = 5'd7;
  localparam op_t OP_MV_WRITE  = 5'd8;
  localparam op_t OP_SCAN      = 5'd9;
  localparam op_t OP_INS_DIFF  = 5'd10;
  localparam op_t OP_INS_SETUP = 5'd11;
  localparam op_t OP_SHIFT     = 5'd12;
  localparam op_t OP_INS_FIN1  = 5'd13;
  localparam op_t OP_INS_FIN2  = 5'd14;
  localparam op_t OP_RM_ISSUE  = 5'd15;
  localparam op_t OP_RM_SETUP  = 5'd16;
  localparam op_t OP_RM_FIN    = 5'd17;

  typedef struct packed {
    op_t  op;
    logic load_out;
  } ctl_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              slot_ok;
    logic              read_ok;
    logic              not_full;
    logic              scan_hit;
    logic              scan_end;
    logic              ins_fit;
    logic              mv_ok;
    logic              shift_busy;
    logic              out_free;
  } sts_t;

endpackage

### hdl/sbt_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for commands and results.
// Depends on sbt_pkg for field widths.
interface sbt_cmd_if import sbt_pkg::*;;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [SLOT_W-1:0] slot;
  logic [IO_W-1:0]   frame;
  logic [IO_W-1:0]   stop_frame;

  modport source (output valid, mode, slot, frame, stop_frame, input ready);
  modport sink (input valid, mode, slot, frame, stop_frame, output ready);
endinterface

interface sbt_rsp_if import sbt_pkg::*;;
  logic               valid;
  logic               ready;
  logic               ok;
  logic [COUNT_W-1:0] slice_count;
  logic [IO_W-1:0]    slice_start;
  logic [IO_W-1:0]    slice_end;

  modport source (output valid, ok, slice_count, slice_start, slice_end, input ready);
  modport sink (input valid, ok, slice_count, slice_start, slice_end, output ready);
endinterface

### hdl/sbt_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on sbt_pkg for default sizes.
module sbt_ram import sbt_pkg::*; #(
  parameter int WIDTH = FRAME_BITS_DEF,
  parameter int DEPTH = MAX_SLICES_DEF,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/sbt_ctrl.sv
`timescale 1ns / 1ps
// Command sequencer for the slice boundary table.
// Depends on sbt_pkg for command codes and the ctl_t/sts_t structs.
module sbt_ctrl import sbt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  sts_t sts,
  output ctl_t ctl
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DECODE    = 4'd1;
  localparam logic [3:0] S_RD_DATA   = 4'd2;
  localparam logic [3:0] S_MV_CALC   = 4'd3;
  localparam logic [3:0] S_MV_CHECK  = 4'd4;
  localparam logic [3:0] S_SCAN      = 4'd5;
  localparam logic [3:0] S_INS_DIFF  = 4'd6;
  localparam logic [3:0] S_INS_CHECK = 4'd7;
  localparam logic [3:0] S_SHIFT     = 4'd8;
  localparam logic [3:0] S_INS_FIN1  = 4'd9;
  localparam logic [3:0] S_INS_FIN2  = 4'd10;
  localparam logic [3:0] S_RM_WR     = 4'd11;
  localparam logic [3:0] S_RM_FIN    = 4'd12;
  localparam logic [3:0] S_DONE      = 4'd13;

  logic [3:0] state;
  logic [3:0] state_next;

  assign cmd_ready = (state == S_IDLE);

  always_comb begin
    state_next   = state;
    ctl.op       = OP_NONE;
    ctl.load_out = 1'b0;
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          ctl.op     = OP_LATCH;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_DONE;
        case (sts.mode)
          MODE_CLEAR: begin
            ctl.op = OP_CLEAR;
          end
          MODE_APPEND: begin
            if (sts.not_full) begin
              ctl.op = OP_APPEND;
            end
          end
          MODE_MOVE: begin
            if (sts.slot_ok) begin
              ctl.op     = OP_MV_ISSUE;
              state_next = S_MV_CALC;
            end
          end
          MODE_INSERT: begin
            state_next = S_SCAN;
          end
          MODE_REMOVE: begin
            if (sts.slot_ok) begin
              ctl.op     = OP_RM_ISSUE;
              state_next = S_RM_WR;
            end
          end
          MODE_READ: begin
            if (sts.read_ok) begin
              ctl.op     = OP_RD_ISSUE;
              state_next = S_RD_DATA;
            end
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      S_RD_DATA: begin
        ctl.op     = OP_RD_LOAD;
        state_next = S_DONE;
      end
      S_MV_CALC: begin
        ctl.op     = OP_MV_CALC;
        state_next = S_MV_CHECK;
      end
      S_MV_CHECK: begin
        if (sts.mv_ok) begin
          ctl.op = OP_MV_WRITE;
        end
        state_next = S_DONE;
      end
      S_SCAN: begin
        ctl.op = OP_SCAN;
        if (sts.scan_hit) begin
          state_next = S_INS_DIFF;
        end else if (sts.scan_end) begin
          state_next = S_DONE;
        end
      end
      S_INS_DIFF: begin
        ctl.op     = OP_INS_DIFF;
        state_next = S_INS_CHECK;
      end
      S_INS_CHECK: begin
        if (sts.ins_fit) begin
          ctl.op     = OP_INS_SETUP;
          state_next = S_SHIFT;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SHIFT: begin
        ctl.op = OP_SHIFT;
        if (!sts.shift_busy) begin
          state_next = (sts.mode == MODE_INSERT) ? S_INS_FIN1 : S_RM_FIN;
        end
      end
      S_INS_FIN1: begin
        ctl.op     = OP_INS_FIN1;
        state_next = S_INS_FIN2;
      end
      S_INS_FIN2: begin
        ctl.op     = OP_INS_FIN2;
        state_next = S_DONE;
      end
      S_RM_WR: begin
        ctl.op     = OP_RM_SETUP;
        state_next = S_SHIFT;
      end
      S_RM_FIN: begin
        ctl.op     = OP_RM_FIN;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          ctl.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### hdl/sbt_datapath.sv
`timescale 1ns / 1ps
// Datapath: command registers, slice start/end memories, scan, shift and
// boundary arithmetic, result register. Depends on sbt_pkg and sbt_ram.
module sbt_datapath import sbt_pkg::*; #(
  parameter int MAX_SLICES = MAX_SLICES_DEF,
  parameter int FRAME_BITS = FRAME_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [MIN_BITS-1:0] min_frames,
  input  logic [MODE_W-1:0]   cmd_mode,
  input  logic [SLOT_W-1:0]   cmd_slot,
  input  logic [IO_W-1:0]     cmd_frame,
  input  logic [IO_W-1:0]     cmd_stop_frame,
  input  logic                rsp_ready,
  output logic                rsp_valid,
  output logic                rsp_ok,
  output logic [COUNT_W-1:0]  rsp_slice_count,
  output logic [IO_W-1:0]     rsp_slice_start,
  output logic [IO_W-1:0]     rsp_slice_end,
  input  ctl_t                ctl,
  output sts_t                sts
);

  localparam int FB     = FRAME_BITS;
  localparam int ADDR_W = $clog2(MAX_SLICES);
  localparam int CNT_W  = $clog2(MAX_SLICES + 1);
  localparam int XW     = ((CNT_W > SLOT_W) ? CNT_W : SLOT_W) + 1;
  localparam int AW     = ((FB > MIN_BITS) ? FB : MIN_BITS) + 1;

  logic [MODE_W-1:0] mode_r;
  logic [SLOT_W-1:0] slot_r;
  logic [FB-1:0]     frame_r;
  logic [FB-1:0]     stop_r;
  logic [CNT_W-1:0]  count;
  logic              res_ok;
  logic [FB-1:0]     res_start;
  logic [FB-1:0]     res_end;

  logic [CNT_W-1:0]  scan_ptr;
  logic              cmp_v;
  logic [ADDR_W-1:0] cmp_addr;
  logic [FB-1:0]     seg_s;
  logic [FB-1:0]     seg_e;
  logic [ADDR_W-1:0] ins_idx;
  logic [FB-1:0]     d1;
  logic [FB-1:0]     d2;
  logic [AW-1:0]     hi_w;
  logic [AW-1:0]     lo_w;

  logic [ADDR_W-1:0] sh_ptr;
  logic [CNT_W-1:0]  sh_left;
  logic              sh_up;
  logic              wr_pend;
  logic [ADDR_W-1:0] wr_addr;

  logic              s_we, s_re, e_we, e_re;
  logic [ADDR_W-1:0] s_waddr, s_raddr, e_waddr, e_raddr;
  logic [FB-1:0]     s_wdata, e_wdata, s_q, e_q;

  logic [MIN_BITS-1:0] m_eff;
  logic [AW-1:0]       m_w;
  logic [AW-1:0]       f_w;
  logic [AW-1:0]       clamp_w;
  logic [FB-1:0]       clamp;
  logic [XW-1:0]       slot_x;
  logic [XW-1:0]       count_x;
  logic [ADDR_W-1:0]   slot_a;
  logic [ADDR_W-1:0]   slot1_a;
  logic [ADDR_W-1:0]   count_a;
  logic                not_full;
  logic                scan_more;
  logic                hit;
  logic                sh_step;

  assign m_eff   = (min_frames == '0) ? MIN_BITS'(1) : min_frames;
  assign m_w     = AW'(m_eff);
  assign f_w     = AW'(frame_r);
  assign slot_x  = XW'(slot_r);
  assign count_x = XW'(count);
  assign slot_a  = slot_x[ADDR_W-1:0];
  assign slot1_a = slot_a + ADDR_W'(1);
  assign count_a = count[ADDR_W-1:0];

  assign not_full  = (count != CNT_W'(MAX_SLICES));
  assign scan_more = (scan_ptr < count);
  assign hit       = cmp_v && (frame_r > s_q) && (frame_r < e_q);
  assign sh_step   = (sh_left != '0);

  // clamp into [lo, hi]; only used once lo <= hi is known
  assign clamp_w = (f_w < lo_w) ? lo_w : ((f_w > hi_w) ? hi_w : f_w);
  assign clamp   = clamp_w[FB-1:0];

  always_comb begin
    sts.mode       = mode_r;
    sts.slot_ok    = (slot_x + XW'(1)) < count_x;
    sts.read_ok    = slot_x < count_x;
    sts.not_full   = not_full;
    sts.scan_hit   = hit;
    sts.scan_end   = !cmp_v && !scan_more;
    sts.ins_fit    = (AW'(d1) >= m_w) && (AW'(d2) >= m_w) && not_full;
    sts.mv_ok      = !hi_w[AW-1] && (lo_w <= hi_w);
    sts.shift_busy = sh_step || wr_pend;
    sts.out_free   = !rsp_valid || rsp_ready;
  end

  // memory port steering
  always_comb begin
    s_we = 1'b0; s_waddr = '0; s_wdata = '0; s_re = 1'b0; s_raddr = '0;
    e_we = 1'b0; e_waddr = '0; e_wdata = '0; e_re = 1'b0; e_raddr = '0;
    case (ctl.op)
      OP_APPEND: begin
        s_we = 1'b1; s_waddr = count_a; s_wdata = frame_r;
        e_we = 1'b1; e_waddr = count_a; e_wdata = stop_r;
      end
      OP_RD_ISSUE: begin
        s_re = 1'b1; s_raddr = slot_a;
        e_re = 1'b1; e_raddr = slot_a;
      end
      OP_MV_ISSUE: begin
        s_re = 1'b1; s_raddr = slot_a;
        e_re = 1'b1; e_raddr = slot1_a;
      end
      OP_MV_WRITE: begin
        e_we = 1'b1; e_waddr = slot_a;  e_wdata = clamp;
        s_we = 1'b1; s_waddr = slot1_a; s_wdata = clamp;
      end
      OP_SCAN: begin
        s_re = scan_more; s_raddr = scan_ptr[ADDR_W-1:0];
        e_re = scan_more; e_raddr = scan_ptr[ADDR_W-1:0];
      end
      OP_SHIFT: begin
        s_re = sh_step; s_raddr = sh_ptr;
        e_re = sh_step; e_raddr = sh_ptr;
        s_we = wr_pend; s_waddr = wr_addr; s_wdata = s_q;
        e_we = wr_pend; e_waddr = wr_addr; e_wdata = e_q;
      end
      OP_INS_FIN1: begin
        e_we = 1'b1; e_waddr = ins_idx;                 e_wdata = frame_r;
        s_we = 1'b1; s_waddr = ins_idx + ADDR_W'(1);    s_wdata = frame_r;
      end
      OP_INS_FIN2: begin
        e_we = 1'b1; e_waddr = ins_idx + ADDR_W'(1); e_wdata = seg_e;
      end
      OP_RM_ISSUE: begin
        e_re = 1'b1; e_raddr = slot1_a;
      end
      OP_RM_SETUP: begin
        e_we = 1'b1; e_waddr = slot_a; e_wdata = e_q;
      end
      default: begin
      end
    endcase
  end

  sbt_ram #(.WIDTH(FB), .DEPTH(MAX_SLICES)) u_start_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .re    (s_re),
    .raddr (s_raddr),
    .rdata (s_q)
  );

  sbt_ram #(.WIDTH(FB), .DEPTH(MAX_SLICES)) u_end_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .re    (e_re),
    .raddr (e_raddr),
    .rdata (e_q)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      cmp_v     <= 1'b0;
      sh_left   <= '0;
      wr_pend   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (ctl.load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (ctl.op)
        OP_LATCH: begin
          cmp_v <= 1'b0;
        end
        OP_CLEAR: begin
          count <= '0;
        end
        OP_APPEND, OP_INS_FIN2: begin
          count <= count + CNT_W'(1);
        end
        OP_RM_FIN: begin
          count <= count - CNT_W'(1);
        end
        OP_SCAN: begin
          cmp_v <= scan_more;
        end
        OP_INS_SETUP: begin
          sh_left <= count - CNT_W'(1) - CNT_W'(ins_idx);
          wr_pend <= 1'b0;
        end
        OP_RM_SETUP: begin
          sh_left <= CNT_W'(count_x - XW'(2) - slot_x);
          wr_pend <= 1'b0;
        end
        OP_SHIFT: begin
          wr_pend <= sh_step;
          if (sh_step) begin
            sh_left <= sh_left - CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      rsp_ok          <= res_ok;
      rsp_slice_count <= COUNT_W'(count);
      rsp_slice_start <= IO_W'(res_start);
      rsp_slice_end   <= IO_W'(res_end);
    end
    case (ctl.op)
      OP_LATCH: begin
        mode_r    <= cmd_mode;
        slot_r    <= cmd_slot;
        frame_r   <= FB'(cmd_frame);
        stop_r    <= FB'(cmd_stop_frame);
        res_ok    <= 1'b0;
        res_start <= '0;
        res_end   <= '0;
        scan_ptr  <= '0;
      end
      OP_CLEAR, OP_APPEND, OP_MV_WRITE, OP_INS_FIN2, OP_RM_FIN: begin
        res_ok <= 1'b1;
      end
      OP_RD_LOAD: begin
        res_ok    <= 1'b1;
        res_start <= s_q;
        res_end   <= e_q;
      end
      OP_MV_CALC: begin
        hi_w <= AW'(e_q) - m_w;
        lo_w <= AW'(s_q) + m_w;
      end
      OP_SCAN: begin
        if (scan_more) begin
          scan_ptr <= scan_ptr + CNT_W'(1);
          cmp_addr <= scan_ptr[ADDR_W-1:0];
        end
        if (hit) begin
          seg_s   <= s_q;
          seg_e   <= e_q;
          ins_idx <= cmp_addr;
        end
      end
      OP_INS_DIFF: begin
        d1 <= frame_r - seg_s;
        d2 <= seg_e - frame_r;
      end
      OP_INS_SETUP: begin
        sh_ptr <= count_a - ADDR_W'(1);
        sh_up  <= 1'b1;
      end
      OP_RM_SETUP: begin
        sh_ptr <= slot_a + ADDR_W'(2);
        sh_up  <= 1'b0;
      end
      OP_SHIFT: begin
        if (sh_step) begin
          sh_ptr  <= sh_up ? (sh_ptr - ADDR_W'(1)) : (sh_ptr + ADDR_W'(1));
          wr_addr <= sh_up ? (sh_ptr + ADDR_W'(1)) : (sh_ptr - ADDR_W'(1));
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### hdl/slice_boundary_table_core.sv
`timescale 1ns / 1ps
// Slice boundary table top level: APB register, sequencer, datapath.
// Insert first scans the table for the slice that holds the frame; insert and remove
// then shift the later entries up or down by one slot. One command in flight; next
// command accepted the cycle after its result is registered.
// Reset (synchronous): table empty, min_slice_frames = 1; memories are not cleared.
module slice_boundary_table_core import sbt_pkg::*; #(
  parameter int MAX_SLICES = MAX_SLICES_DEF,
  parameter int FRAME_BITS = FRAME_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  sbt_cmd_if.sink           cmd,
  sbt_rsp_if.source         rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  logic [MIN_BITS-1:0] min_frames;
  logic                cmd_ready;
  ctl_t                ctl;
  sts_t                sts;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MIN_SLICE) ? APB_DW'(min_frames) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_frames <= MIN_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_MIN_SLICE)) begin
      min_frames <= pwdata[MIN_BITS-1:0];
    end
  end

  assign cmd.ready = cmd_ready;

  sbt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd_ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  sbt_datapath #(
    .MAX_SLICES (MAX_SLICES),
    .FRAME_BITS (FRAME_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .min_frames      (min_frames),
    .cmd_mode        (cmd.mode),
    .cmd_slot        (cmd.slot),
    .cmd_frame       (cmd.frame),
    .cmd_stop_frame  (cmd.stop_frame),
    .rsp_ready       (rsp.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ok          (rsp.ok),
    .rsp_slice_count (rsp.slice_count),
    .rsp_slice_start (rsp.slice_start),
    .rsp_slice_end   (rsp.slice_end),
    .ctl             (ctl),
    .sts             (sts)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    cmd.valid && cmd.ready |=> !cmd.ready)
    else $error("command accepted while another is in flight");

  a_data_only_on_ok: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.slice_start != '0 || rsp.slice_end != '0) |-> rsp.ok)
    else $error("slice data on a rejected transaction");

  a_append_room: assert property (@(posedge clk) disable iff (rst)
    ctl.op == OP_APPEND |-> sts.not_full)
    else $error("append issued on a full table");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    ctl.load_out |-> sts.out_free)
    else $error("result overwritten before it was taken");

endmodule
